// ===== hdl/ring_pool_allocator_defines.svh =====
// assertion macros used by the ring pool allocator controller
`ifndef RING_POOL_ALLOCATOR_DEFINES_SVH
`define RING_POOL_ALLOCATOR_DEFINES_SVH

// plain property checked on every clock edge outside reset
`define RPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define RPA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/rpa_pkg.sv =====
// shared types and constants of the ring pool allocator
package rpa_pkg;

  // fixed field widths of the stream items
  localparam int unsigned AMOUNT_W = 13;
  localparam int unsigned RSLOT_W  = 8;
  localparam int unsigned START_W  = 12;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned USED_W   = 13;
  localparam int unsigned STATUS_W = 2;

  // packed stream widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } rpa_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_QUEUE_FULL = 2'd2
  } rpa_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REL,
    S_CHK
  } rpa_state_e;

  // one request item
  typedef struct packed {
    rpa_op_e              op;
    logic [AMOUNT_W-1:0]  amount;
    logic [RSLOT_W-1:0]   release_slot;
  } rpa_item_t;

  // one result item
  typedef struct packed {
    rpa_status_e          status;
    logic [START_W-1:0]   start_offset;
    logic [SLOT_W-1:0]    granted_slot;
    logic [USED_W-1:0]    words_in_use;
  } rpa_result_t;

endpackage

// ===== hdl/ring_pool_allocator.sv =====
// top level of the ring pool allocator: stream ports and output register
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid_i/tready_o       tdata amount, release_slot; tuser operation
//  m_axis    out  m_axis_tvalid_o/tready_i       tdata status, start_offset, granted_slot,
//                                                words_in_use
//
// a release result is loaded from the S_REL state once the output register is free;
// an allocate result is loaded from the S_CHK state once the output register is free
// and the released blocks at the head of the queue are retired, one per cycle through the
// single read port of the block store. no new item is taken until its result is loaded.
// reset clears the state, pointers, counts and output valid only; the block store needs no clearing pass.
// a result held in the output register stalls only the end of the following item.
module ring_pool_allocator #(
  parameter int unsigned POOL_WORDS = 4096,
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [12:0] amount, [20:13] release_slot, [23:21] zero
  input  logic [rpa_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // [0] operation
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [1:0] status, [13:2] start_offset, [21:14] granted_slot, [34:22] words_in_use,
  // [39:35] zero
  output logic [rpa_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);

  rpa_pkg::rpa_item_t   item;
  rpa_pkg::rpa_result_t res;
  logic                 res_load;
  logic                 out_free;
  logic                 m_valid_q, m_valid_d;
  logic [rpa_pkg::OUT_DATA_W-1:0] m_data_q, m_data_d;

  // unpack the request
  always_comb begin
    item.op           = rpa_pkg::rpa_op_e'(s_axis_tuser_i);
    item.amount       = s_axis_tdata_i[12:0];
    item.release_slot = s_axis_tdata_i[20:13];
  end

  rpa_ctrl #(
    .POOL_WORDS (POOL_WORDS),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_item_i  (item),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .res_load_o (res_load),
    .res_o      (res)
  );

  // output register control
  always_comb begin
    out_free  = !m_valid_q || m_axis_tready_i;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (res_load) begin
      m_valid_d = 1'b1;
      m_data_d  = {5'b0, res.words_in_use, res.granted_slot, res.start_offset, res.status};
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ===== hdl/rpa_ram.sv =====
// simple dual port ram with registered read data
module rpa_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, old data on collision
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ===== hdl/rpa_ctrl.sv =====
// sequencer, pool pointers and block queue of the ring pool allocator
`include "ring_pool_allocator_defines.svh"

module rpa_ctrl #(
  parameter int unsigned POOL_WORDS = 4096,
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  rpa_pkg::rpa_item_t  in_item_i,
  output logic                in_ready_o,
  input  logic                out_free_i,
  output logic                res_load_o,
  output rpa_pkg::rpa_result_t res_o
);

  localparam int unsigned AW    = rpa_pkg::AMOUNT_W;
  localparam int unsigned PW    = $clog2(POOL_WORDS);
  localparam int unsigned UW    = $clog2(POOL_WORDS + 1);
  localparam int unsigned SW    = $clog2(MAX_BLOCKS);
  localparam int unsigned CW    = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SUM_W = ((UW > AW) ? UW : AW) + 1;

  rpa_pkg::rpa_state_e state_q, state_d;

  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [UW-1:0] used_q, used_d;
  logic [SW-1:0] front_q, front_d;
  logic [SW-1:0] back_q, back_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] amt_q, amt_d;

  // block store ports
  logic          len_wr_en;
  logic          mark_wr_en;
  logic          mark_wr_data;
  logic [SW-1:0] mark_wr_addr;
  logic [SW-1:0] rd_addr;
  logic [AW-1:0] len_rd;
  logic          mark_rd;

  logic          accept;
  logic          retire;
  logic          fits;
  logic          full;
  logic          rslot_ok;
  logic [SW-1:0] rslot_idx;
  logic [SW-1:0] front_inc;
  logic [SW-1:0] back_inc;
  logic [SUM_W-1:0] head_sum, head_wrap;
  logic [SUM_W-1:0] tail_sum, tail_wrap;
  logic [SUM_W-1:0] used_sum, used_sub;
  logic [31:0]   rslot_ext, tail_ext, back_ext, used_ext, used_d_ext;

  rpa_ram #(.WIDTH(AW), .DEPTH(MAX_BLOCKS)) u_len_ram (
    .clk_i     (clk_i),
    .wr_en_i   (len_wr_en),
    .wr_addr_i (back_q),
    .wr_data_i (amt_q),
    .rd_addr_i (rd_addr),
    .rd_data_o (len_rd)
  );

  rpa_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_mark_ram (
    .clk_i     (clk_i),
    .wr_en_i   (mark_wr_en),
    .wr_addr_i (mark_wr_addr),
    .wr_data_i (mark_wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (mark_rd)
  );

  // pointer arithmetic and fit checks
  always_comb begin
    accept    = in_valid_i && in_ready_o;
    retire    = (count_q != '0) && mark_rd;
    full      = (count_q == CW'(MAX_BLOCKS));
    rslot_ext = 32'(in_item_i.release_slot);
    rslot_ok  = (rslot_ext < 32'(MAX_BLOCKS));
    rslot_idx = rslot_ext[SW-1:0];
    front_inc = (front_q == SW'(MAX_BLOCKS - 1)) ? '0 : front_q + 1'b1;
    back_inc  = (back_q == SW'(MAX_BLOCKS - 1)) ? '0 : back_q + 1'b1;
    head_sum  = SUM_W'(head_q) + SUM_W'(len_rd);
    head_wrap = (head_sum >= SUM_W'(POOL_WORDS)) ? head_sum - SUM_W'(POOL_WORDS) : head_sum;
    tail_sum  = SUM_W'(tail_q) + SUM_W'(amt_q);
    tail_wrap = (tail_sum >= SUM_W'(POOL_WORDS)) ? tail_sum - SUM_W'(POOL_WORDS) : tail_sum;
    used_sum  = SUM_W'(used_q) + SUM_W'(amt_q);
    used_sub  = (SUM_W'(used_q) >= SUM_W'(len_rd)) ? SUM_W'(used_q) - SUM_W'(len_rd) : '0;
    fits      = (used_sum <= SUM_W'(POOL_WORDS));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpa_pkg::S_IDLE: begin
        if (accept) begin
          state_d = (in_item_i.op == rpa_pkg::OP_RELEASE) ? rpa_pkg::S_REL : rpa_pkg::S_CHK;
        end
      end
      rpa_pkg::S_REL: begin
        if (out_free_i) begin
          state_d = rpa_pkg::S_IDLE;
        end
      end
      rpa_pkg::S_CHK: begin
        if (!retire && out_free_i) begin
          state_d = rpa_pkg::S_IDLE;
        end
      end
      default: state_d = rpa_pkg::S_IDLE;
    endcase
  end

  // outputs, store strobes and datapath updates
  always_comb begin
    in_ready_o   = 1'b0;
    res_load_o   = 1'b0;
    len_wr_en    = 1'b0;
    mark_wr_en   = 1'b0;
    mark_wr_data = 1'b0;
    mark_wr_addr = back_q;
    rd_addr      = front_q;
    head_d       = head_q;
    tail_d       = tail_q;
    used_d       = used_q;
    front_d      = front_q;
    back_d       = back_q;
    count_d      = count_q;
    amt_d        = amt_q;
    tail_ext     = 32'(tail_q);
    back_ext     = 32'(back_q);
    used_ext     = 32'(used_q);
    used_d_ext   = 32'(used_sum[UW-1:0]);
    res_o.status       = rpa_pkg::ST_OK;
    res_o.start_offset = '0;
    res_o.granted_slot = '0;
    res_o.words_in_use = used_ext[rpa_pkg::USED_W-1:0];
    unique case (state_q)
      rpa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          amt_d = in_item_i.amount;
          // release marks the slot at once
          if (in_item_i.op == rpa_pkg::OP_RELEASE && rslot_ok) begin
            mark_wr_en   = 1'b1;
            mark_wr_data = 1'b1;
            mark_wr_addr = rslot_idx;
          end
        end
      end
      rpa_pkg::S_REL: begin
        res_load_o = out_free_i;
      end
      rpa_pkg::S_CHK: begin
        if (retire) begin
          // retire the oldest block and fetch the next one
          head_d  = head_wrap[PW-1:0];
          used_d  = used_sub[UW-1:0];
          front_d = front_inc;
          count_d = count_q - 1'b1;
          rd_addr = front_inc;
        end else if (out_free_i) begin
          res_load_o = 1'b1;
          if (!fits) begin
            res_o.status = rpa_pkg::ST_NO_SPACE;
          end else if (full) begin
            res_o.status = rpa_pkg::ST_QUEUE_FULL;
          end else begin
            // grant at the tail and record the block
            len_wr_en          = 1'b1;
            mark_wr_en         = 1'b1;
            mark_wr_data       = 1'b0;
            mark_wr_addr       = back_q;
            back_d             = back_inc;
            count_d            = count_q + 1'b1;
            tail_d             = tail_wrap[PW-1:0];
            used_d             = used_sum[UW-1:0];
            res_o.start_offset = tail_ext[rpa_pkg::START_W-1:0];
            res_o.granted_slot = back_ext[rpa_pkg::SLOT_W-1:0];
            res_o.words_in_use = used_d_ext[rpa_pkg::USED_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // control and pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpa_pkg::S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      used_q  <= '0;
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      used_q  <= used_d;
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  // latched request amount
  always_ff @(posedge clk_i) begin
    amt_q <= amt_d;
  end

  `RPA_ASSERT(a_count_bound, count_q <= CW'(MAX_BLOCKS), "block count above queue depth")
  `RPA_ASSERT(a_used_bound, used_q <= UW'(POOL_WORDS), "used words above pool size")
  `RPA_ASSERT(a_ends_meet, (count_q == '0 || count_q == CW'(MAX_BLOCKS)) |-> (front_q == back_q), "queue ends disagree with count")
  `RPA_ASSERT_NEXT(a_retire_step, state_q == rpa_pkg::S_CHK && retire, count_q == $past(count_q) - 1'b1, "retire did not drop count by one")
  `RPA_ASSERT(a_load_free, res_load_o |-> out_free_i, "result loaded into a busy output register")

endmodule
